@@ rtl/modbus_rtu_slave_engine_top_defines.svh @@
// ----------------------------------------------------------------------------
// modbus rtu slave engine assertion macros
// shared concurrent assertion forms, clocked on clock
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_SLAVE_ENGINE_TOP_DEFINES_SVH
`define MODBUS_RTU_SLAVE_ENGINE_TOP_DEFINES_SVH

// checked outside reset only
`define MRSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define MRSE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/mrse_pkg.sv @@
// ----------------------------------------------------------------------------
// mrse_pkg
// constants and types of the modbus rtu slave engine
// ----------------------------------------------------------------------------
`default_nettype none

package mrse_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;

   localparam logic     OP_BYTE       = 1'b0;
   localparam logic     OP_FRAME_END  = 1'b1;

   localparam word_type CRC_INIT      = 16'hFFFF;
   localparam word_type CRC_POLY      = 16'hA001;
   localparam word_type READ_OFFSET   = 16'd40000;
   localparam word_type MAX_READ_REGS = 16'd20;

   localparam byte_type FC_READ       = 8'd3;
   localparam byte_type FC_WRITE_ONE  = 8'd6;
   localparam byte_type FC_WRITE_MANY = 8'd16;

   localparam byte_type ADDR_RESET    = 8'h3C;

   function automatic word_type hreg_reset(input int idx);
      word_type v;
      case (idx)
         0: v = 16'h5042;
         1: v = 16'h0102;
         3: v = 16'h010C;
         4: v = 16'h0001;
         5: v = 16'h0005;
         6: v = 16'h003C;
         default: v = 16'h0000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mrse_ram.sv @@
// ----------------------------------------------------------------------------
// mrse_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mrse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ rtl/modbus_rtu_slave_engine_top.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_slave_engine_top
// modbus rtu slave: frame buffer, crc check, register read and write, reply
// ----------------------------------------------------------------------------
// A received byte (req_opcode OP_BYTE) is taken and busy stays low, so
// bytes may come every cycle. A frame end (req_opcode OP_FRAME_END) runs
// the frame check through a bit-serial crc unit, one bit per cycle; a
// multiple-write request then writes its registers one by one. Reply bytes
// then leave on rsp_strobe, the crc bytes last; busy is high for all of
// this. The station address can be written only while busy is low. The
// receiver cannot stall: each reply byte is valid for exactly the one cycle
// of rsp_strobe.
`default_nettype none
`include "modbus_rtu_slave_engine_top_defines.svh"

module modbus_rtu_slave_engine_top
   import mrse_pkg::*;
#(
   parameter int REG_COUNT   = 20,
   parameter int FRAME_BYTES = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_opcode,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_last_byte,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_wdata
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int LW = $clog2(FRAME_BYTES + 1);
   localparam int RW = $clog2(REG_COUNT);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RD_ISSUE = 4'd1;
   localparam logic [3:0] S_RD_DATA  = 4'd2;
   localparam logic [3:0] S_CRC      = 4'd3;
   localparam logic [3:0] S_CHECK    = 4'd4;
   localparam logic [3:0] S_WR_ISSUE = 4'd5;
   localparam logic [3:0] S_WR_HI    = 4'd6;
   localparam logic [3:0] S_WR_LO    = 4'd7;
   localparam logic [3:0] S_EMIT     = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] idx_ff, idx_in;
   byte_type      hdr_ff [6];
   byte_type      hdr_in [6];
   word_type      rxcrc_ff, rxcrc_in;
   word_type      crc_ff, crc_in;
   logic [2:0]    bit_ff, bit_in;
   logic          emit_ff, emit_in;
   logic          fc3_ff, fc3_in;
   logic [RW-1:0] rptr_ff, rptr_in;
   logic          lo_ff, lo_in;
   logic [RW:0]   wcnt_ff, wcnt_in;
   byte_type      whi_ff, whi_in;
   logic [5:0]    k_ff, k_in;
   logic [5:0]    nd_ff, nd_in;
   byte_type      cnt_ff, cnt_in;
   word_type      hreg_ff [REG_COUNT];
   word_type      hreg_in [REG_COUNT];
   byte_type      slave_ff, slave_in;
   logic          strobe_ff, strobe_in;
   byte_type      tx_ff, tx_in;
   logic          last_ff, last_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   byte_type      ram_rdata;

   word_type      w2, w4, ra;
   logic [LW-1:0] len_m1, len_m2;
   logic          crc_ok, rd_ok, wr1_ok, wrn_ok;
   logic [LW-1:0] idx_p1;
   byte_type      ebyte;

   mrse_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_rx_byte),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign busy          = (state_ff != S_IDLE);
   assign csr_ready     = !busy;
   assign rsp_strobe    = strobe_ff;
   assign rsp_tx_byte   = tx_ff;
   assign rsp_last_byte = last_ff;

   assign ram_we    = (state_ff == S_IDLE) && start && (req_opcode == OP_BYTE)
                      && (len_ff < LW'(FRAME_BYTES));
   assign ram_waddr = len_ff[AW-1:0];
   assign idx_p1    = idx_ff + LW'(1);
   assign ram_raddr = (state_ff == S_WR_HI) ? idx_p1[AW-1:0] : idx_ff[AW-1:0];

   assign w2     = {hdr_ff[2], hdr_ff[3]};
   assign w4     = {hdr_ff[4], hdr_ff[5]};
   assign ra     = (w2 >= READ_OFFSET) ? (w2 - READ_OFFSET) : w2;
   assign len_m1 = len_ff - LW'(1);
   assign len_m2 = len_ff - LW'(2);
   assign crc_ok = (crc_ff == rxcrc_ff) && (hdr_ff[0] == slave_ff);
   assign rd_ok  = (len_ff == LW'(8)) && (w4 != 16'd0) && (w4 <= MAX_READ_REGS)
                   && (({1'b0, ra} + {1'b0, w4}) <= 17'(REG_COUNT));
   assign wr1_ok = (len_ff == LW'(8)) && (w2 < 16'(REG_COUNT));
   assign wrn_ok = (len_ff >= LW'(9)) && (w4 != 16'd0)
                   && (({1'b0, w2} + {1'b0, w4}) <= 17'(REG_COUNT))
                   && (18'(len_ff) >= ({1'b0, w4, 1'b0} + 18'd9));

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      hdr_in    = hdr_ff;
      rxcrc_in  = rxcrc_ff;
      crc_in    = crc_ff;
      bit_in    = bit_ff;
      emit_in   = emit_ff;
      fc3_in    = fc3_ff;
      rptr_in   = rptr_ff;
      lo_in     = lo_ff;
      wcnt_in   = wcnt_ff;
      whi_in    = whi_ff;
      k_in      = k_ff;
      nd_in     = nd_ff;
      cnt_in    = cnt_ff;
      hreg_in   = hreg_ff;
      slave_in  = slave_ff;
      strobe_in = 1'b0;
      tx_in     = tx_ff;
      last_in   = 1'b0;
      ebyte     = hdr_ff[k_ff[2:0]];

      if (csr_valid && csr_ready) begin
         slave_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_opcode == OP_BYTE) begin
                  if (len_ff < LW'(FRAME_BYTES)) begin
                     len_in = len_ff + LW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (len_ff < LW'(4) || ovf_ff) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = '0;
                  crc_in   = CRC_INIT;
                  emit_in  = 1'b0;
                  state_in = S_RD_ISSUE;
               end
            end
         end
         S_RD_ISSUE: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            if (idx_ff < LW'(6)) begin
               hdr_in[idx_ff[2:0]] = ram_rdata;
            end
            if (idx_ff == len_m2) begin
               rxcrc_in[7:0] = ram_rdata;
            end
            if (idx_ff == len_m1) begin
               rxcrc_in[15:8] = ram_rdata;
            end
            if (idx_ff < len_m2) begin
               crc_in   = crc_ff ^ {8'h00, ram_rdata};
               bit_in   = '0;
               state_in = S_CRC;
            end else if (idx_ff == len_m1) begin
               state_in = S_CHECK;
            end else begin
               idx_in   = idx_p1;
               state_in = S_RD_ISSUE;
            end
         end
         S_CRC: begin
            crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               if (emit_ff) begin
                  k_in     = k_ff + 6'd1;
                  state_in = S_EMIT;
               end else begin
                  idx_in   = idx_p1;
                  state_in = S_RD_ISSUE;
               end
            end
         end
         S_CHECK: begin
            k_in     = '0;
            lo_in    = 1'b0;
            emit_in  = 1'b1;
            crc_in   = CRC_INIT;
            fc3_in   = 1'b0;
            nd_in    = 6'd6;
            state_in = S_DONE;
            if (crc_ok) begin
               case (hdr_ff[1])
                  FC_READ: begin
                     if (rd_ok) begin
                        fc3_in   = 1'b1;
                        rptr_in  = ra[RW-1:0];
                        nd_in    = 6'd3 + {w4[4:0], 1'b0};
                        cnt_in   = {w4[6:0], 1'b0};
                        state_in = S_EMIT;
                     end
                  end
                  FC_WRITE_ONE: begin
                     if (wr1_ok) begin
                        hreg_in[w2[RW-1:0]] = w4;
                        state_in = S_EMIT;
                     end
                  end
                  FC_WRITE_MANY: begin
                     if (wrn_ok) begin
                        rptr_in  = w2[RW-1:0];
                        wcnt_in  = w4[RW:0];
                        idx_in   = LW'(7);
                        state_in = S_WR_ISSUE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_WR_ISSUE: begin
            state_in = S_WR_HI;
         end
         S_WR_HI: begin
            whi_in   = ram_rdata;
            state_in = S_WR_LO;
         end
         S_WR_LO: begin
            hreg_in[rptr_ff] = {whi_ff, ram_rdata};
            rptr_in = rptr_ff + RW'(1);
            idx_in  = idx_ff + LW'(2);
            wcnt_in = wcnt_ff - (RW+1)'(1);
            state_in = (wcnt_ff == (RW+1)'(1)) ? S_EMIT : S_WR_ISSUE;
         end
         S_EMIT: begin
            strobe_in = 1'b1;
            if (k_ff < nd_ff) begin
               if (fc3_ff) begin
                  if (k_ff == 6'd0) begin
                     ebyte = hdr_ff[0];
                  end else if (k_ff == 6'd1) begin
                     ebyte = FC_READ;
                  end else if (k_ff == 6'd2) begin
                     ebyte = cnt_ff;
                  end else begin
                     ebyte = lo_ff ? hreg_ff[rptr_ff][7:0] : hreg_ff[rptr_ff][15:8];
                     lo_in = !lo_ff;
                     if (lo_ff) begin
                        rptr_in = rptr_ff + RW'(1);
                     end
                  end
               end
               tx_in    = ebyte;
               crc_in   = crc_ff ^ {8'h00, ebyte};
               bit_in   = '0;
               state_in = S_CRC;
            end else if (k_ff == nd_ff) begin
               tx_in = crc_ff[7:0];
               k_in  = k_ff + 6'd1;
            end else begin
               tx_in    = crc_ff[15:8];
               last_in  = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            len_in   = '0;
            ovf_in   = 1'b0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         slave_ff  <= ADDR_RESET;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) begin
            hreg_ff[i] <= hreg_reset(i);
         end
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         slave_ff  <= slave_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
         hreg_ff   <= hreg_in;
      end
      idx_ff   <= idx_in;
      hdr_ff   <= hdr_in;
      rxcrc_ff <= rxcrc_in;
      crc_ff   <= crc_in;
      bit_ff   <= bit_in;
      emit_ff  <= emit_in;
      fc3_ff   <= fc3_in;
      rptr_ff  <= rptr_in;
      lo_ff    <= lo_in;
      wcnt_ff  <= wcnt_in;
      whi_ff   <= whi_in;
      k_ff     <= k_in;
      nd_ff    <= nd_in;
      cnt_ff   <= cnt_in;
      tx_ff    <= tx_in;
   end

   // a reply byte only ever leaves while a frame end is being worked
   `MRSE_ASSERT(a_strobe_busy, rsp_strobe |-> busy, "reply byte outside frame-end work")
   `MRSE_ASSERT(a_last_strobe, rsp_last_byte |-> rsp_strobe, "last byte without strobe")
   `MRSE_ASSERT(a_last_ends, rsp_last_byte |=> !rsp_strobe && !busy, "reply runs past last byte")
   `MRSE_ASSERT(a_len_bound, len_ff <= LW'(FRAME_BYTES), "frame length past buffer")
   `MRSE_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_strobe && !busy, "active after reset")

endmodule

`default_nettype wire
